[design/conv2d_multichannel_relu_top_assert.svh]
// Assertion macros for the conv2d block checker.
// Used by design/c2d_checker.sv; needs nothing else.
`ifndef CONV2D_MULTICHANNEL_RELU_TOP_ASSERT_SVH
`define CONV2D_MULTICHANNEL_RELU_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define C2D_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define C2D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/c2d_pkg.sv]
// Shared types and constants for the conv2d block.
// No dependencies; compiled before every other file of the block.
`timescale 1ns / 1ps

package c2d_pkg;

   // Store size defaults
   localparam int MAX_CHANNELS_DEF = 16;
   localparam int MAX_MAP_SIZE_DEF = 32;
   localparam int MAX_KERNEL_DEF   = 5;

   // Item field widths
   localparam int OP_W      = 2;
   localparam int ADDR_W    = 14;
   localparam int DATA_W    = 16;
   localparam int CHAN_W    = 4;
   localparam int POS_W     = 5;
   localparam int PIX_IDX_W = 14;

   // Register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_IMAGE  = 2'd0,
      OP_LOAD_WEIGHT = 2'd1,
      OP_LOAD_BIAS   = 2'd2,
      OP_COMPUTE     = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IN_CHANNELS  = 3'd0,
      REG_OUT_CHANNELS = 3'd1,
      REG_IN_SIZE      = 3'd2,
      REG_OUT_SIZE     = 3'd3,
      REG_KERNEL_SIZE  = 3'd4,
      REG_STRIDE       = 3'd5,
      REG_PADDING      = 3'd6,
      REG_MODE         = 3'd7
   } reg_idx_type;

   // Sequencer controls for the multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic tap_valid;
      logic add_bias;
      logic relu;
   } mac_ctl_type;

endpackage

[design/c2d_if.sv]
// Valid/ready channels for request items and result items.
// Depends on c2d_pkg for field widths.
`timescale 1ns / 1ps

interface c2d_req_if;
   import c2d_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [ADDR_W-1:0]        addr;
   logic signed [DATA_W-1:0] data_in;
   logic [CHAN_W-1:0]        out_chan;
   logic [POS_W-1:0]         out_row;
   logic [POS_W-1:0]         out_col;

   modport source (output valid, op, addr, data_in, out_chan, out_row, out_col,
                   input ready);
   modport sink   (input valid, op, addr, data_in, out_chan, out_row, out_col,
                   output ready);
endinterface

interface c2d_rsp_if;
   import c2d_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] pixel_value;
   logic [PIX_IDX_W-1:0]     pixel_index;

   modport source (output valid, pixel_value, pixel_index, input ready);
   modport sink   (input valid, pixel_value, pixel_index, output ready);
endinterface

[design/c2d_mac.sv]
// Shared multiply-accumulate unit with bias add, ReLU, rounding and saturation.
// Depends on c2d_pkg (mac_ctl_type, DATA_W).
`timescale 1ns / 1ps

module c2d_mac #(
   parameter int ACC_W = 42
) (
   input  logic                              clock,
   input  logic                              reset,
   input  c2d_pkg::mac_ctl_type              ctl,
   input  logic signed [c2d_pkg::DATA_W-1:0] img,
   input  logic signed [c2d_pkg::DATA_W-1:0] wgt,
   input  logic signed [c2d_pkg::DATA_W-1:0] bias,
   output logic signed [c2d_pkg::DATA_W-1:0] result
);
   import c2d_pkg::*;

   localparam int PROD_W = 2 * DATA_W;
   localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(128);

   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  relu_val;
   logic signed [ACC_W-1:0]  scaled;

   // Product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctl.tap_valid;
      end
      prod_ff <= PROD_W'(img) * PROD_W'(wgt);
   end

   // Accumulator: products in Q16.16, bias enters as bias << 8
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end else if (ctl.add_bias) begin
         acc_ff <= acc_ff + (ACC_W'(bias) <<< 8);
      end
   end

   // ReLU, round to nearest with ties up, saturate to Q8.8
   always_comb begin
      relu_val = (ctl.relu && acc_ff[ACC_W-1]) ? '0 : acc_ff;
      scaled   = (relu_val + HALF_LSB) >>> 8;
      if (scaled > SAT_HI) begin
         result = SAT_HI[DATA_W-1:0];
      end else if (scaled < SAT_LO) begin
         result = SAT_LO[DATA_W-1:0];
      end else begin
         result = scaled[DATA_W-1:0];
      end
   end

endmodule

[design/conv2d_multichannel_relu_top.sv]
// Multi-channel 2D convolution with stride, zero padding, bias and ReLU, one output
// pixel per compute item. Load items (image, weight, bias) are taken while idle and
// give no result. A compute item runs on one shared multiply-accumulate unit, one
// kernel tap per cycle, and holds the block busy until its result is registered; the
// block is ready for the next item in the same cycle that the result goes valid. The
// item steps through two setup states, the tap loop over the image and weight store
// read ports, a drain state, a bias step and an output step. A previous result
// still stalled on the result side holds the block in its output step. Requests outside
// the configured output map give no result and leave the block ready. Reading a
// store entry that was never written yields an undefined pixel value. Registers must
// be written only while the block is idle; the block itself does not enforce this.
// Depends on c2d_pkg, c2d_if and c2d_mac.
`timescale 1ns / 1ps

module conv2d_multichannel_relu_top #(
   parameter int MAX_CHANNELS = c2d_pkg::MAX_CHANNELS_DEF,
   parameter int MAX_MAP_SIZE = c2d_pkg::MAX_MAP_SIZE_DEF,
   parameter int MAX_KERNEL   = c2d_pkg::MAX_KERNEL_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [c2d_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [c2d_pkg::CSR_DATA_W-1:0]    csr_data,
   c2d_req_if.sink                           req_if,
   c2d_rsp_if.source                         rsp_if
);
   import c2d_pkg::*;

   localparam int IMG_DEPTH  = MAX_CHANNELS * MAX_MAP_SIZE * MAX_MAP_SIZE;
   localparam int WGT_DEPTH  = MAX_CHANNELS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
   localparam int BIAS_DEPTH = MAX_CHANNELS;
   localparam int IMG_AW     = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
   localparam int WGT_AW     = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
   localparam int BIAS_AW    = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
   localparam int ACC_W      = 2 * DATA_W + 1 + $clog2(MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL + 1);
   localparam int YX_W       = 10;
   localparam int ROW_W      = 17;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP0,
      ST_SETUP1,
      ST_TAP,
      ST_DRAIN,
      ST_BIAS,
      ST_DONE
   } state_type;

   // Configuration registers
   logic [4:0] cfg_ic_ff, cfg_ocn_ff;
   logic [5:0] cfg_isz_ff, cfg_osz_ff;
   logic [2:0] cfg_ks_ff, cfg_stride_ff, cfg_pad_ff;
   logic [1:0] cfg_mode_ff;

   // Effective (capped) sizes
   logic [4:0] eff_ic, eff_ocn;
   logic [5:0] eff_isz, eff_osz;
   logic [2:0] eff_ks;

   // Sequencer state
   state_type              state_ff;
   logic [CHAN_W-1:0]      oc_ff;
   logic [POS_W-1:0]       row_ff, col_ff;
   logic [5:0]             ksq_ff;
   logic [8:0]             ocic_ff;
   logic [9:0]             pix_a_ff;
   logic [PIX_IDX_W-1:0]   pix_idx_ff;
   logic signed [YX_W-1:0] y0_ff, x0_ff, yv_ff, xv_ff;
   logic [IMG_AW-1:0]      isq_ff, y0isz_ff, row_off_ff, ch_base_ff;
   logic [WGT_AW-1:0]      wa_ff;
   logic [4:0]             c_ff;
   logic [2:0]             i_ff, j_ff;
   logic                   rd_vld_ff;
   logic                   drain_ff;

   // Result register
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] pixel_value_ff;
   logic [PIX_IDX_W-1:0]     pixel_index_ff;

   // Stores and their read data
   logic [DATA_W-1:0]        image_mem [IMG_DEPTH];
   logic [DATA_W-1:0]        weight_mem [WGT_DEPTH];
   logic [DATA_W-1:0]        bias_mem [BIAS_DEPTH];
   logic signed [DATA_W-1:0] image_rd_ff, weight_rd_ff, bias_rd_ff;

   logic                     req_fire;
   logic                     req_in_range;
   logic                     tap_ok;
   logic [IMG_AW-1:0]        img_addr;
   logic signed [ROW_W-1:0]  y0isz_w;
   mac_ctl_type              mac_ctl;
   logic signed [DATA_W-1:0] mac_result;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ic_ff     <= 5'd1;
         cfg_ocn_ff    <= 5'd1;
         cfg_isz_ff    <= 6'd32;
         cfg_osz_ff    <= 6'd32;
         cfg_ks_ff     <= 3'd3;
         cfg_stride_ff <= 3'd1;
         cfg_pad_ff    <= 3'd1;
         cfg_mode_ff   <= 2'd0;
      end else if (csr_wr_en) begin
         unique case (reg_idx_type'(csr_index))
            REG_IN_CHANNELS:  cfg_ic_ff     <= csr_data[4:0];
            REG_OUT_CHANNELS: cfg_ocn_ff    <= csr_data[4:0];
            REG_IN_SIZE:      cfg_isz_ff    <= csr_data[5:0];
            REG_OUT_SIZE:     cfg_osz_ff    <= csr_data[5:0];
            REG_KERNEL_SIZE:  cfg_ks_ff     <= csr_data[2:0];
            REG_STRIDE:       cfg_stride_ff <= csr_data[2:0];
            REG_PADDING:      cfg_pad_ff    <= csr_data[2:0];
            REG_MODE:         cfg_mode_ff   <= csr_data[1:0];
         endcase
      end
   end

   // Size caps
   always_comb begin
      eff_ic  = (32'(cfg_ic_ff)  > MAX_CHANNELS) ? 5'(MAX_CHANNELS) : cfg_ic_ff;
      eff_ocn = (32'(cfg_ocn_ff) > MAX_CHANNELS) ? 5'(MAX_CHANNELS) : cfg_ocn_ff;
      eff_isz = (32'(cfg_isz_ff) > MAX_MAP_SIZE) ? 6'(MAX_MAP_SIZE) : cfg_isz_ff;
      eff_osz = (32'(cfg_osz_ff) > MAX_MAP_SIZE) ? 6'(MAX_MAP_SIZE) : cfg_osz_ff;
      eff_ks  = (32'(cfg_ks_ff)  > MAX_KERNEL)   ? 3'(MAX_KERNEL)   : cfg_ks_ff;
   end

   // Handshake and request check
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign req_in_range = ({1'b0, req_if.out_chan} < eff_ocn) &&
                         ({1'b0, req_if.out_row} < eff_osz) &&
                         ({1'b0, req_if.out_col} < eff_osz);

   // Current tap: bounds check and image address (modulo the store size)
   assign tap_ok = !yv_ff[YX_W-1] && (yv_ff < $signed(YX_W'(eff_isz))) &&
                   !xv_ff[YX_W-1] && (xv_ff < $signed(YX_W'(eff_isz)));
   assign img_addr = ch_base_ff + row_off_ff + IMG_AW'(xv_ff);
   assign y0isz_w  = ROW_W'(y0_ff) * ROW_W'($signed({1'b0, eff_isz}));

   // Store writes on load items, tap and bias reads for the sequencer
   always_ff @(posedge clock) begin
      if (req_fire && (req_if.op == OP_LOAD_IMAGE) && (32'(req_if.addr) < IMG_DEPTH)) begin
         image_mem[IMG_AW'(req_if.addr)] <= req_if.data_in;
      end
      if (req_fire && (req_if.op == OP_LOAD_WEIGHT) && (32'(req_if.addr) < WGT_DEPTH)) begin
         weight_mem[WGT_AW'(req_if.addr)] <= req_if.data_in;
      end
      if (req_fire && (req_if.op == OP_LOAD_BIAS) && (32'(req_if.addr) < BIAS_DEPTH)) begin
         bias_mem[BIAS_AW'(req_if.addr)] <= req_if.data_in;
      end
      if ((state_ff == ST_TAP) && tap_ok) begin
         image_rd_ff  <= image_mem[img_addr];
         weight_rd_ff <= weight_mem[wa_ff];
      end
      if (state_ff == ST_SETUP0) begin
         bias_rd_ff <= bias_mem[BIAS_AW'(oc_ff)];
      end
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= (state_ff == ST_TAP) && tap_ok;
         // the output step reloads the result register itself
         if (rsp_valid_ff && rsp_if.ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_if.op == OP_COMPUTE) && req_in_range) begin
                  oc_ff    <= req_if.out_chan;
                  row_ff   <= req_if.out_row;
                  col_ff   <= req_if.out_col;
                  state_ff <= ST_SETUP0;
               end
            end
            // window origin, kernel and map areas
            ST_SETUP0: begin
               ksq_ff   <= 6'(eff_ks) * 6'(eff_ks);
               ocic_ff  <= 9'(oc_ff) * 9'(eff_ic);
               y0_ff    <= $signed(YX_W'(row_ff) * YX_W'(cfg_stride_ff)) -
                           $signed(YX_W'(cfg_pad_ff));
               x0_ff    <= $signed(YX_W'(col_ff) * YX_W'(cfg_stride_ff)) -
                           $signed(YX_W'(cfg_pad_ff));
               isq_ff   <= IMG_AW'(12'(eff_isz) * 12'(eff_isz));
               pix_a_ff <= 10'(oc_ff) * 10'(eff_osz) + 10'(row_ff);
               state_ff <= ST_SETUP1;
            end
            // base addresses, loop counters
            ST_SETUP1: begin
               wa_ff      <= WGT_AW'(16'(ocic_ff) * 16'(ksq_ff));
               y0isz_ff   <= IMG_AW'(y0isz_w);
               row_off_ff <= IMG_AW'(y0isz_w);
               pix_idx_ff <= PIX_IDX_W'(16'(pix_a_ff) * 16'(eff_osz) + 16'(col_ff));
               ch_base_ff <= '0;
               c_ff       <= '0;
               i_ff       <= '0;
               j_ff       <= '0;
               yv_ff      <= y0_ff;
               xv_ff      <= x0_ff;
               drain_ff   <= 1'b0;
               if ((eff_ic == 5'd0) || (eff_ks == 3'd0)) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  state_ff <= ST_TAP;
               end
            end
            // one tap per cycle: column, then row, then channel
            ST_TAP: begin
               wa_ff <= wa_ff + WGT_AW'(1);
               if (j_ff + 3'd1 == eff_ks) begin
                  j_ff  <= '0;
                  xv_ff <= x0_ff;
                  if (i_ff + 3'd1 == eff_ks) begin
                     i_ff       <= '0;
                     yv_ff      <= y0_ff;
                     row_off_ff <= y0isz_ff;
                     ch_base_ff <= ch_base_ff + isq_ff;
                     c_ff       <= c_ff + 5'd1;
                     if (c_ff + 5'd1 == eff_ic) begin
                        drain_ff <= 1'b0;
                        state_ff <= ST_DRAIN;
                     end
                  end else begin
                     i_ff       <= i_ff + 3'd1;
                     yv_ff      <= yv_ff + YX_W'(1);
                     row_off_ff <= row_off_ff + IMG_AW'(eff_isz);
                  end
               end else begin
                  j_ff  <= j_ff + 3'd1;
                  xv_ff <= xv_ff + YX_W'(1);
               end
            end
            // let the last products reach the accumulator
            ST_DRAIN: begin
               drain_ff <= 1'b1;
               if (drain_ff) begin
                  state_ff <= ST_BIAS;
               end
            end
            ST_BIAS: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  pixel_value_ff <= mac_result;
                  pixel_index_ff <= pix_idx_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Accumulator controls
   always_comb begin
      mac_ctl.clear     = (state_ff == ST_SETUP0);
      mac_ctl.tap_valid = rd_vld_ff;
      mac_ctl.add_bias  = (state_ff == ST_BIAS) && cfg_mode_ff[1];
      mac_ctl.relu      = (cfg_mode_ff != 2'd0);
   end

   c2d_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .img    (image_rd_ff),
      .wgt    (weight_rd_ff),
      .bias   (bias_rd_ff),
      .result (mac_result)
   );

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.pixel_value = pixel_value_ff;
   assign rsp_if.pixel_index = pixel_index_ff;

endmodule

[design/c2d_checker.sv]
// Port-level assertions for the conv2d block, bound to its top level.
// Depends on c2d_pkg, c2d_if and conv2d_multichannel_relu_top_assert.svh.
`timescale 1ns / 1ps
`include "conv2d_multichannel_relu_top_assert.svh"

module c2d_checker (
   input logic       clock,
   input logic       reset,
   c2d_req_if.sink   req_if,
   c2d_rsp_if.source rsp_if
);
   import c2d_pkg::*;

   // a stalled result item holds
   `C2D_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_if.valid && !rsp_if.ready, rsp_if.valid && $stable(rsp_if.pixel_value) && $stable(rsp_if.pixel_index), "stalled result item changed")

   // no result appears the cycle after an item is taken
   `C2D_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_if.valid && req_if.ready, !$rose(rsp_if.valid), "result appeared right after an accept")

   // a new result comes only out of a busy period
   `C2D_ASSERT_SAME(a_rsp_after_busy, clock, reset, $rose(rsp_if.valid), $past(!req_if.ready), "result rose while the input side was idle")

   // a load item never leaves the block busy
   `C2D_ASSERT_NEXT(a_load_stays_ready, clock, reset, req_if.valid && req_if.ready && (req_if.op != OP_COMPUTE), req_if.ready, "block went busy after a load item")

endmodule

bind conv2d_multichannel_relu_top c2d_checker u_c2d_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);

[tb/c2d_pixel_checker.sv]
// Checker for the conv2d block: mirrors the stores and registers, predicts each pixel.
// Watches the request, result and register ports; needs c2d_pkg and c2d_if.
`timescale 1ns / 1ps

module c2d_pixel_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [c2d_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [c2d_pkg::CSR_DATA_W-1:0] csr_data,
   c2d_req_if                             req,
   c2d_rsp_if                             rsp,
   output int                             fail_count,
   output int                             pending
);
   import c2d_pkg::*;

   localparam int IMG_WORDS  = MAX_CHANNELS_DEF * MAX_MAP_SIZE_DEF * MAX_MAP_SIZE_DEF;
   localparam int WGT_WORDS  = MAX_CHANNELS_DEF * MAX_CHANNELS_DEF *
                               MAX_KERNEL_DEF * MAX_KERNEL_DEF;
   localparam int BIAS_WORDS = MAX_CHANNELS_DEF;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic [PIX_IDX_W-1:0]     index;
   } pixel_type;

   // Mirrored stores and registers
   logic signed [DATA_W-1:0] image_mem  [IMG_WORDS];
   logic signed [DATA_W-1:0] weight_mem [WGT_WORDS];
   logic signed [DATA_W-1:0] bias_mem   [BIAS_WORDS];

   logic [4:0] in_ch_r, out_ch_r;
   logic [5:0] in_sz_r, out_sz_r;
   logic [2:0] ks_r, stride_r, pad_r;
   logic [1:0] mode_r;

   // Pixels predicted but not yet seen on the result port
   pixel_type pixel_q [$];

   function automatic int clip(input int v, input int hi);
      return (v > hi) ? hi : v;
   endfunction

   // Predict one output pixel; returns 0 when the request gives no result
   function automatic bit conv_pixel(input logic [CHAN_W-1:0] oc,
                                     input logic [POS_W-1:0] row,
                                     input logic [POS_W-1:0] col,
                                     output pixel_type px);
      int     ic, ocn, isz, osz, ks, yv, xv, ia, wa;
      longint acc, rnd;
      ic  = clip(int'(in_ch_r), MAX_CHANNELS_DEF);
      ocn = clip(int'(out_ch_r), MAX_CHANNELS_DEF);
      isz = clip(int'(in_sz_r), MAX_MAP_SIZE_DEF);
      osz = clip(int'(out_sz_r), MAX_MAP_SIZE_DEF);
      ks  = clip(int'(ks_r), MAX_KERNEL_DEF);
      px.value = '0;
      px.index = '0;
      if (int'(oc) >= ocn || int'(row) >= osz || int'(col) >= osz) return 0;
      acc = 0;
      for (int c = 0; c < ic; c++) begin
         for (int i = 0; i < ks; i++) begin
            for (int j = 0; j < ks; j++) begin
               yv = int'(row) * int'(stride_r) + i - int'(pad_r);
               xv = int'(col) * int'(stride_r) + j - int'(pad_r);
               // taps in the zero border add nothing
               if (yv < 0 || xv < 0 || yv >= isz || xv >= isz) continue;
               ia = (c * isz + yv) * isz + xv;
               wa = ((int'(oc) * ic + c) * ks + i) * ks + j;
               acc += longint'(image_mem[ia]) * longint'(weight_mem[wa]);
            end
         end
      end
      if (mode_r >= 2) acc += longint'(bias_mem[oc]) * 256;
      if (mode_r >= 1 && acc < 0) acc = 0;
      // Q16.16 to Q8.8, round half up, then saturate
      rnd = (acc + 128) >>> 8;
      if (rnd > 32767) rnd = 32767;
      else if (rnd < -32768) rnd = -32768;
      px.value = rnd[DATA_W-1:0];
      px.index = PIX_IDX_W'((int'(oc) * osz + int'(row)) * osz + int'(col));
      return 1;
   endfunction

   initial begin
      for (int k = 0; k < IMG_WORDS; k++) image_mem[k] = '0;
      for (int k = 0; k < WGT_WORDS; k++) weight_mem[k] = '0;
      for (int k = 0; k < BIAS_WORDS; k++) bias_mem[k] = '0;
   end

   // Result check first, then the request item of the same edge
   always @(posedge clock) begin
      pixel_type got, want, px;
      int        errs;
      errs = 0;
      if (reset) begin
         in_ch_r  = 5'd1;
         out_ch_r = 5'd1;
         in_sz_r  = 6'd32;
         out_sz_r = 6'd32;
         ks_r     = 3'd3;
         stride_r = 3'd1;
         pad_r    = 3'd1;
         mode_r   = 2'd0;
         pixel_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (reg_idx_type'(csr_index))
               REG_IN_CHANNELS:  in_ch_r  = csr_data[4:0];
               REG_OUT_CHANNELS: out_ch_r = csr_data[4:0];
               REG_IN_SIZE:      in_sz_r  = csr_data[5:0];
               REG_OUT_SIZE:     out_sz_r = csr_data[5:0];
               REG_KERNEL_SIZE:  ks_r     = csr_data[2:0];
               REG_STRIDE:       stride_r = csr_data[2:0];
               REG_PADDING:      pad_r    = csr_data[2:0];
               REG_MODE:         mode_r   = csr_data[1:0];
               default: ;
            endcase
         end

         if (rsp.valid && rsp.ready) begin
            got.value = rsp.pixel_value;
            got.index = rsp.pixel_index;
            if (pixel_q.size() == 0) begin
               $error("unexpected result item: pixel_index %0d pixel_value %0d",
                      got.index, $signed(got.value));
               errs++;
            end else begin
               want = pixel_q.pop_front();
               if (got.value !== want.value) begin
                  $error("pixel_value mismatch: expected %0d, actual %0d",
                         $signed(want.value), $signed(got.value));
                  errs++;
               end
               if (got.index !== want.index) begin
                  $error("pixel_index mismatch: expected %0d, actual %0d",
                         want.index, got.index);
                  errs++;
               end
            end
         end

         if (req.valid && req.ready) begin
            case (op_type'(req.op))
               OP_LOAD_IMAGE:
                  if (int'(req.addr) < IMG_WORDS) image_mem[req.addr] = req.data_in;
               OP_LOAD_WEIGHT:
                  if (int'(req.addr) < WGT_WORDS) weight_mem[req.addr] = req.data_in;
               OP_LOAD_BIAS:
                  if (int'(req.addr) < BIAS_WORDS) bias_mem[req.addr] = req.data_in;
               OP_COMPUTE:
                  if (conv_pixel(req.out_chan, req.out_row, req.out_col, px))
                     pixel_q.insert(pixel_q.size(), px);
               default: ;
            endcase
         end
         fail_count <= fail_count + errs;
      end
      pending <= pixel_q.size();
   end

endmodule

[tb/conv2d_multichannel_relu_top_tb.sv]
// Testbench top for the conv2d block: clock, reset, register writes and request items.
// Needs c2d_pkg, c2d_if, the block itself and c2d_pixel_checker.
`timescale 1ns / 1ps

module conv2d_multichannel_relu_top_tb;
   import c2d_pkg::*;

   localparam int IMG_WORDS   = MAX_CHANNELS_DEF * MAX_MAP_SIZE_DEF * MAX_MAP_SIZE_DEF;
   localparam int WGT_WORDS   = MAX_CHANNELS_DEF * MAX_CHANNELS_DEF *
                                MAX_KERNEL_DEF * MAX_KERNEL_DEF;
   localparam int BIAS_WORDS  = MAX_CHANNELS_DEF;
   localparam int NUM_PHASES  = 16;
   localparam int PHASE_ITEMS = 65;
   localparam int SETTLE_CYC  = 450;
   localparam int CYCLE_LIMIT = 3000000;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    fail_count;
   int                    pending;

   c2d_req_if req_bus ();
   c2d_rsp_if rsp_bus ();

   conv2d_multichannel_relu_top dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus)
   );

   c2d_pixel_checker u_pix_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Register settings per phase:
   // in_ch, out_ch, in_size, out_size, kernel, stride, padding, mode
   int phase_cfg [NUM_PHASES][8] = '{
      '{ 2,  3,  6,  6, 3, 1, 1, 1},
      '{ 1, 16,  8,  8, 1, 1, 0, 2},
      '{ 3,  2,  5,  3, 2, 2, 0, 3},
      '{ 0,  2,  8,  4, 3, 1, 1, 2},   // no input channels
      '{ 2,  0,  8,  4, 3, 1, 1, 0},   // no output filters
      '{ 1,  1,  0,  4, 3, 1, 1, 1},   // empty input map
      '{ 2,  2,  6,  4, 0, 1, 0, 2},   // empty kernel
      '{ 2,  2,  6,  0, 3, 1, 0, 0},   // empty output map
      '{ 2,  2,  7,  5, 3, 0, 2, 1},   // zero stride
      '{ 1,  2,  4,  8, 5, 4, 4, 2},
      '{16,  2,  2,  2, 5, 1, 2, 2},   // full tap loop on a tiny map
      '{31, 31,  2, 63, 7, 7, 7, 3},   // oversized values get capped
      '{ 1,  1, 63,  2, 1, 1, 0, 0},
      '{ 1,  1, 32, 32, 3, 1, 1, 0},
      '{ 1,  1,  1,  1, 1, 1, 0, 1},
      '{ 8, 16, 32, 32, 1, 1, 0, 2}
   };

   int cfg_mirror [8] = '{1, 1, 32, 32, 3, 1, 1, 0};

   // Store entries already written, so no compute reads an undefined word
   bit img_written  [IMG_WORDS];
   bit wgt_written  [WGT_WORDS];
   bit bias_written [BIAS_WORDS];

   int send_idle_pct [3] = '{34, 80, 0};
   int recv_idle_pct [3] = '{80, 34, 0};
   int idle_sel;
   int items_sent;
   int cycle_cnt;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result side back-pressure, with short stretches of none
   always @(posedge clock) begin
      if ((cycle_cnt % 200) < 30)
         rsp_bus.ready <= 1'b1;
      else
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct[idle_sel]);
   end

   // Watchdog
   initial begin
      cycle_cnt = 0;
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("Verification failed");
      $finish;
   end

   function automatic int reg_width(input int r);
      case (reg_idx_type'(r))
         REG_IN_CHANNELS, REG_OUT_CHANNELS: return 5;
         REG_IN_SIZE, REG_OUT_SIZE:         return 6;
         REG_MODE:                          return 2;
         default:                           return 3;
      endcase
   endfunction

   // Register value as the block uses it, after capping
   function automatic int eff(input reg_idx_type r);
      int v;
      v = cfg_mirror[r];
      case (r)
         REG_IN_CHANNELS, REG_OUT_CHANNELS: return (v > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : v;
         REG_IN_SIZE, REG_OUT_SIZE:         return (v > MAX_MAP_SIZE_DEF) ? MAX_MAP_SIZE_DEF : v;
         REG_KERNEL_SIZE:                   return (v > MAX_KERNEL_DEF) ? MAX_KERNEL_DEF : v;
         default:                           return v;
      endcase
   endfunction

   // Mostly small words so sums stay in range, some full scale and extremes
   function automatic logic [DATA_W-1:0] rand_word();
      case ($urandom_range(9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return DATA_W'($urandom);
         3, 4:    return DATA_W'(int'($urandom_range(8191)) - 4096);
         default: return DATA_W'(int'($urandom_range(1023)) - 512);
      endcase
   endfunction

   function automatic int pick_pos(input int lim);
      if (lim > 0 && $urandom_range(9) < 6) return $urandom_range(lim - 1);
      return $urandom_range(31);
   endfunction

   task automatic send_item(input op_type op, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data, input logic [CHAN_W-1:0] chan,
                            input logic [POS_W-1:0] row, input logic [POS_W-1:0] col);
      int pct;
      pct = ((items_sent % 50) < 10) ? 0 : send_idle_pct[idle_sel];
      if ($urandom_range(99) < pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < pct);
      end
      req_bus.valid    <= 1'b1;
      req_bus.op       <= op;
      req_bus.addr     <= addr;
      req_bus.data_in  <= data;
      req_bus.out_chan <= chan;
      req_bus.out_row  <= row;
      req_bus.out_col  <= col;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_load(input op_type op, input int addr, input logic [DATA_W-1:0] data);
      case (op)
         OP_LOAD_IMAGE:  if (addr < IMG_WORDS) img_written[addr] = 1'b1;
         OP_LOAD_WEIGHT: if (addr < WGT_WORDS) wgt_written[addr] = 1'b1;
         OP_LOAD_BIAS:   if (addr < BIAS_WORDS) bias_written[addr] = 1'b1;
         default: ;
      endcase
      send_item(op, ADDR_W'(addr), data, CHAN_W'($urandom), POS_W'($urandom),
                POS_W'($urandom));
   endtask

   // Load whatever the pixel will read that is still unwritten, then ask for it
   task automatic send_pixel_request(input int oc, input int row, input int col);
      int ic, ocn, isz, osz, ks, st, pd, yv, xv, ia, wa;
      ic  = eff(REG_IN_CHANNELS);
      ocn = eff(REG_OUT_CHANNELS);
      isz = eff(REG_IN_SIZE);
      osz = eff(REG_OUT_SIZE);
      ks  = eff(REG_KERNEL_SIZE);
      st  = eff(REG_STRIDE);
      pd  = eff(REG_PADDING);
      if (oc < ocn && row < osz && col < osz) begin
         for (int c = 0; c < ic; c++) begin
            for (int i = 0; i < ks; i++) begin
               for (int j = 0; j < ks; j++) begin
                  yv = row * st + i - pd;
                  xv = col * st + j - pd;
                  if (yv < 0 || xv < 0 || yv >= isz || xv >= isz) continue;
                  ia = (c * isz + yv) * isz + xv;
                  wa = ((oc * ic + c) * ks + i) * ks + j;
                  if (!img_written[ia]) send_load(OP_LOAD_IMAGE, ia, rand_word());
                  if (!wgt_written[wa]) send_load(OP_LOAD_WEIGHT, wa, rand_word());
               end
            end
         end
         if (eff(REG_MODE) >= 2 && !bias_written[oc])
            send_load(OP_LOAD_BIAS, oc, rand_word());
      end
      send_item(OP_COMPUTE, ADDR_W'($urandom), DATA_W'($urandom), CHAN_W'(oc),
                POS_W'(row), POS_W'(col));
   endtask

   // Let the block finish and drain before touching registers or ending
   task automatic wait_block_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_regs(input int phase);
      int w, val;
      for (int r = 0; r < 8; r++) begin
         val = phase_cfg[phase][r];
         w   = reg_width(r);
         csr_wr_en <= 1'b1;
         csr_index <= reg_idx_type'(r);
         // junk above the register width must be dropped
         if (w < CSR_DATA_W && $urandom_range(1))
            csr_data <= CSR_DATA_W'(val | ($urandom << w));
         else
            csr_data <= CSR_DATA_W'(val);
         cfg_mirror[r] = val & ((1 << w) - 1);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int pick, ocn, osz, phase_start;
      idle_sel   = 0;
      items_sent = 0;
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_index        <= REG_IN_CHANNELS;
      csr_data         <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.op       <= OP_LOAD_IMAGE;
      req_bus.addr     <= '0;
      req_bus.data_in  <= '0;
      req_bus.out_chan <= '0;
      req_bus.out_row  <= '0;
      req_bus.out_col  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items at the reset settings
      send_load(OP_LOAD_IMAGE, IMG_WORDS - 1, 16'h7FFF);
      send_load(OP_LOAD_IMAGE, 0, 16'h8000);
      send_load(OP_LOAD_WEIGHT, WGT_WORDS - 1, 16'hFFFF);
      send_load(OP_LOAD_WEIGHT, WGT_WORDS, 16'h1234);     // past the weight store
      send_load(OP_LOAD_BIAS, BIAS_WORDS - 1, 16'h8000);
      send_load(OP_LOAD_BIAS, BIAS_WORDS, 16'h7FFF);      // past the bias store
      send_load(OP_LOAD_BIAS, 16383, 16'h0001);
      send_pixel_request(0, 0, 0);
      send_pixel_request(0, 31, 31);
      send_pixel_request(0, 0, 31);
      send_pixel_request(15, 31, 31);                     // filter out of range
      send_pixel_request(1, 0, 0);

      // Random items, one register setting per phase
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_block_idle();
         idle_sel = (ph < 5) ? 0 : (ph < 11) ? 1 : 2;
         write_regs(ph);
         ocn = eff(REG_OUT_CHANNELS);
         osz = eff(REG_OUT_SIZE);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
               send_pixel_request((ocn > 0 && $urandom_range(3) != 0) ?
                                  $urandom_range(ocn - 1) : $urandom_range(15),
                                  pick_pos(osz), pick_pos(osz));
            end else if (pick < 82) begin
               case ($urandom_range(2))
                  0:       send_load(OP_LOAD_IMAGE, $urandom_range(IMG_WORDS - 1),
                                     rand_word());
                  1:       send_load(OP_LOAD_WEIGHT, $urandom_range(WGT_WORDS - 1),
                                     rand_word());
                  default: send_load(OP_LOAD_BIAS, $urandom_range(BIAS_WORDS - 1),
                                     rand_word());
               endcase
            end else if (pick < 92) begin
               // dropped loads
               if ($urandom_range(1))
                  send_load(OP_LOAD_WEIGHT, $urandom_range(16383, WGT_WORDS), rand_word());
               else
                  send_load(OP_LOAD_BIAS, $urandom_range(16383, BIAS_WORDS), rand_word());
            end else begin
               send_pixel_request($urandom_range(15), $urandom_range(31),
                                  $urandom_range(31));
            end
         end
      end

      wait_block_idle();
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
